/* rtl/core/assert_macros.svh */
// Assertion macros used by the RTL of the page allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge and switched off while reset is low.
`define TPA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Concurrent check sampled on the rising clock edge that also holds during reset.
`define TPA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/tpa_pkg.sv */
// Shared types and fixed constants of the two-pool page allocator.
`timescale 1ns / 1ps
`default_nettype none

package tpa_pkg;

    // Byte address width of configuration registers and stream fields.
    localparam int ADDR_W   = 56;
    localparam int STATUS_W = 3;
    localparam int FREE_W   = 13;

    // Stream word widths.
    localparam int IN_UW  = 3;
    localparam int OUT_DW = 80;
    localparam int OUT_PAD = OUT_DW - (ADDR_W + STATUS_W + 1 + FREE_W);

    // Configuration port.
    localparam int APB_DW = 64;
    localparam int APB_AW = 4;

    // Register index, taken from byte address bit 3.
    localparam logic REG_AREA_BEGIN = 1'b0;
    localparam logic REG_AREA_END   = 1'b1;

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_CHECK = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK          = 3'd0,
        STAT_EXHAUSTED   = 3'd1,
        STAT_BAD_FREE    = 3'd2,
        STAT_DOUBLE_FREE = 3'd3,
        STAT_EMPTY_AREA  = 3'd4
    } status_t;

endpackage

`default_nettype wire

/* rtl/core/two_pool_page_allocator_unit.sv */
// Top level of the two-pool page allocator: control, pool state and stack/map memories.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tuser = {pool, mode}, s_tdata = address
// m_        out        m_tvalid / m_tready  m_tdata = {free_pages, is_kernel, status, page_address}
// APB       in         psel / penable       area_begin at 0x0, area_end at 0x8
//
// Allocate, free and check: the accept edge reads the stack and free-map memories, and
// the execute step uses the read data and writes back once the output register is free.
// Initialize runs a sizing step, a split step, a sweep that writes one stack entry and
// one free-map bit per pool each cycle, and a finish step; an empty area skips to finish.
// Reset clears state, output valid, counts and pool ranges; the memories are not cleared,
// as no read data is used before a sweep writes it. No clearing pass runs after reset.
// A finished result waits in the output register while the next word is accepted; a
// stalled output holds the execute step until the register frees up.

`include "assert_macros.svh"

module two_pool_page_allocator_unit
    import tpa_pkg::*;
#(
    parameter int PAGE_BITS  = 12,
    parameter int POOL_PAGES = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ADDR_W-1:0] s_tdata,   // [55:0] address
    input  logic [IN_UW-1:0]  s_tuser,   // [1:0] mode, [2] pool

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata,   // [55:0] page_address, [58:56] status,
                                         // [59] is_kernel, [72:60] free_pages, rest zero

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Page number width, stack index width and pool count width.
    localparam int PG_W  = ADDR_W - PAGE_BITS;
    localparam int IDX_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int CNT_W = $clog2(POOL_PAGES + 1);
    localparam int PGS_W = CNT_W + 1;
    localparam int DIF_W = PG_W + 2;

    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(POOL_PAGES);
    localparam logic [CNT_W-1:0] SWEEP_END = CNT_W'(POOL_PAGES - 1);
    localparam logic [PGS_W-1:0] PGS_MAX   = PGS_W'(2 * POOL_PAGES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_INIT_SIZE,
        ST_INIT_SPLIT,
        ST_SWEEP,
        ST_FIN
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers. Bit 3 of the byte address picks the register;
    // data bits above the register width are dropped.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] area_begin_reg;
    logic [ADDR_W-1:0] area_end_reg;
    logic              cfg_wr;
    logic [ADDR_W-1:0] cfg_rd_val;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_begin_reg <= '0;
            area_end_reg   <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3])
                REG_AREA_BEGIN: area_begin_reg <= pwdata[ADDR_W-1:0];
                REG_AREA_END:   area_end_reg   <= pwdata[ADDR_W-1:0];
                default:        area_begin_reg <= area_begin_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            REG_AREA_BEGIN: cfg_rd_val = area_begin_reg;
            REG_AREA_END:   cfg_rd_val = area_end_reg;
            default:        cfg_rd_val = '0;
        endcase
    end

    // Addresses that are not on a register boundary read as zero.
    assign prdata = (paddr[2:0] == 3'd0) ? {{(APB_DW - ADDR_W){1'b0}}, cfg_rd_val} : '0;

    // ------------------------------------------------------------------
    // Control and pool state.
    // ------------------------------------------------------------------
    state_t             state_reg;
    mode_t              mode_reg;
    logic               pool_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [PG_W:0]      bp_reg;
    logic [PG_W-1:0]    ep_reg;
    logic [PGS_W-1:0]   pages_reg;
    logic [CNT_W-1:0]   sweep_reg;
    status_t            fin_status_reg;

    logic [CNT_W-1:0]   kcount_reg;
    logic [CNT_W-1:0]   ucount_reg;
    logic [PG_W-1:0]    kbase_reg;
    logic [PG_W-1:0]    split_reg;
    logic [PG_W-1:0]    end_reg;

    logic               m_valid_reg;
    logic [ADDR_W-1:0]  m_page_reg;
    status_t            m_status_reg;
    logic               m_kern_reg;
    logic [FREE_W-1:0]  m_free_reg;

    logic               rd_en;
    logic               out_free;
    logic               do_exec;

    assign s_tready = (state_reg == ST_IDLE);
    assign rd_en    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign do_exec  = (state_reg == ST_EXEC) && out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, m_free_reg, m_kern_reg, m_status_reg, m_page_reg};

    // Page bounds of the configured area: begin rounded up, end rounded down.
    logic [PG_W:0]   bp_calc;
    logic [PG_W-1:0] ep_calc;

    assign bp_calc = {1'b0, area_begin_reg[ADDR_W-1:PAGE_BITS]}
                   + (PG_W + 1)'(|area_begin_reg[PAGE_BITS-1:0]);
    assign ep_calc = area_end_reg[ADDR_W-1:PAGE_BITS];

    // Area size, checked for emptiness and clamped to twice the pool capacity.
    logic [DIF_W-1:0] area_diff;
    logic             area_empty;
    logic [PGS_W-1:0] area_pages;

    assign area_diff  = {2'b00, ep_reg} - {1'b0, bp_reg};
    assign area_empty = area_diff[DIF_W-1] || (area_diff < DIF_W'(2));
    assign area_pages = (area_diff > DIF_W'(2 * POOL_PAGES)) ? PGS_MAX
                                                              : area_diff[PGS_W-1:0];

    // Kernel pool takes the lower half, the user pool the rest.
    logic [CNT_W-1:0] kp_calc;
    logic [PGS_W-1:0] up_wide;

    assign kp_calc = pages_reg[PGS_W-1:1];
    assign up_wide = pages_reg - PGS_W'(kp_calc);

    // ------------------------------------------------------------------
    // Stack and free-map memories, one of each per pool. Reads are issued
    // on the accept edge and held until the next accepted word.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] kstk_mem [POOL_PAGES];
    logic [IDX_W-1:0] ustk_mem [POOL_PAGES];
    logic             kmap_mem [POOL_PAGES];
    logic             umap_mem [POOL_PAGES];

    logic [IDX_W-1:0] kstk_rdata_reg;
    logic [IDX_W-1:0] ustk_rdata_reg;
    logic             kmap_rdata_reg;
    logic             umap_rdata_reg;

    logic [CNT_W-1:0] kcount_dec;
    logic [CNT_W-1:0] ucount_dec;
    logic [IDX_W-1:0] in_pg_low;
    logic [IDX_W-1:0] kmap_raddr;
    logic [IDX_W-1:0] umap_raddr;

    assign kcount_dec = kcount_reg - CNT_W'(1);
    assign ucount_dec = ucount_reg - CNT_W'(1);
    assign in_pg_low  = s_tdata[PAGE_BITS +: IDX_W];
    assign kmap_raddr = in_pg_low - kbase_reg[IDX_W-1:0];
    assign umap_raddr = in_pg_low - split_reg[IDX_W-1:0];

    logic             kstk_we;
    logic [IDX_W-1:0] kstk_waddr;
    logic [IDX_W-1:0] kstk_wdata;
    logic             ustk_we;
    logic [IDX_W-1:0] ustk_waddr;
    logic [IDX_W-1:0] ustk_wdata;
    logic             kmap_we;
    logic [IDX_W-1:0] kmap_waddr;
    logic             kmap_wdata;
    logic             umap_we;
    logic [IDX_W-1:0] umap_waddr;
    logic             umap_wdata;

    always_ff @(posedge aclk) begin
        if (kstk_we) begin
            kstk_mem[kstk_waddr] <= kstk_wdata;
        end
        if (rd_en) begin
            kstk_rdata_reg <= kstk_mem[kcount_dec[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (ustk_we) begin
            ustk_mem[ustk_waddr] <= ustk_wdata;
        end
        if (rd_en) begin
            ustk_rdata_reg <= ustk_mem[ucount_dec[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (kmap_we) begin
            kmap_mem[kmap_waddr] <= kmap_wdata;
        end
        if (rd_en) begin
            kmap_rdata_reg <= kmap_mem[kmap_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (umap_we) begin
            umap_mem[umap_waddr] <= umap_wdata;
        end
        if (rd_en) begin
            umap_rdata_reg <= umap_mem[umap_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Execute step for allocate, free and check.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  sel_count;
    logic [PG_W-1:0]   sel_lo;
    logic [PG_W-1:0]   sel_hi;
    logic [IDX_W-1:0]  sel_stk;
    logic              sel_map;
    logic [PG_W-1:0]   req_pg;
    logic [PG_W-1:0]   pg_off;
    logic              free_valid;
    logic [IDX_W-1:0]  free_off;
    logic [PG_W-1:0]   alloc_pg;

    logic              exec_pop;
    logic              exec_push;
    status_t           exec_status;
    logic [ADDR_W-1:0] exec_page;
    logic              exec_kern;
    logic [CNT_W-1:0]  exec_count;

    assign sel_count = pool_reg ? kcount_reg : ucount_reg;
    assign sel_lo    = pool_reg ? kbase_reg : split_reg;
    assign sel_hi    = pool_reg ? split_reg : end_reg;
    assign sel_stk   = pool_reg ? kstk_rdata_reg : ustk_rdata_reg;
    assign sel_map   = pool_reg ? kmap_rdata_reg : umap_rdata_reg;

    assign req_pg     = addr_reg[ADDR_W-1:PAGE_BITS];
    assign pg_off     = req_pg - sel_lo;
    assign free_valid = (addr_reg[PAGE_BITS-1:0] == '0) && (req_pg >= sel_lo)
                     && (req_pg < sel_hi) && (pg_off < PG_W'(POOL_PAGES));
    assign free_off   = pg_off[IDX_W-1:0];
    assign alloc_pg   = sel_lo + PG_W'(sel_stk);

    always_comb begin
        exec_pop    = 1'b0;
        exec_push   = 1'b0;
        exec_status = STAT_OK;
        exec_page   = '0;
        exec_kern   = 1'b0;
        exec_count  = sel_count;
        case (mode_reg)
            MODE_ALLOC: begin
                if (sel_count == '0) begin
                    exec_status = STAT_EXHAUSTED;
                end else begin
                    // Pop the most recently pushed page.
                    exec_pop   = 1'b1;
                    exec_count = sel_count - CNT_W'(1);
                    exec_page  = {alloc_pg, {PAGE_BITS{1'b0}}};
                end
            end
            MODE_FREE: begin
                if (!free_valid) begin
                    exec_status = STAT_BAD_FREE;
                end else if (sel_map || (sel_count >= CNT_MAX)) begin
                    exec_status = STAT_DOUBLE_FREE;
                end else begin
                    exec_push  = 1'b1;
                    exec_count = sel_count + CNT_W'(1);
                end
            end
            default: begin
                // Kernel range check; an initialize never reaches this step.
                exec_kern = (req_pg >= kbase_reg) && (req_pg < split_reg);
            end
        endcase
    end

    // Memory write ports: the initialize sweep, or a pop or push of the selected pool.
    always_comb begin
        kstk_we    = 1'b0;
        kstk_waddr = sweep_reg[IDX_W-1:0];
        kstk_wdata = sweep_reg[IDX_W-1:0];
        ustk_we    = 1'b0;
        ustk_waddr = sweep_reg[IDX_W-1:0];
        ustk_wdata = sweep_reg[IDX_W-1:0];
        kmap_we    = 1'b0;
        kmap_waddr = sweep_reg[IDX_W-1:0];
        kmap_wdata = sweep_reg < kcount_reg;
        umap_we    = 1'b0;
        umap_waddr = sweep_reg[IDX_W-1:0];
        umap_wdata = sweep_reg < ucount_reg;
        if (state_reg == ST_SWEEP) begin
            kstk_we = 1'b1;
            ustk_we = 1'b1;
            kmap_we = 1'b1;
            umap_we = 1'b1;
        end else if (do_exec && exec_pop) begin
            kmap_we    = pool_reg;
            umap_we    = !pool_reg;
            kmap_waddr = sel_stk;
            umap_waddr = sel_stk;
            kmap_wdata = 1'b0;
            umap_wdata = 1'b0;
        end else if (do_exec && exec_push) begin
            kmap_we    = pool_reg;
            umap_we    = !pool_reg;
            kmap_waddr = free_off;
            umap_waddr = free_off;
            kmap_wdata = 1'b1;
            umap_wdata = 1'b1;
            kstk_we    = pool_reg;
            ustk_we    = !pool_reg;
            kstk_waddr = sel_count[IDX_W-1:0];
            ustk_waddr = sel_count[IDX_W-1:0];
            kstk_wdata = free_off;
            ustk_wdata = free_off;
        end
    end

    // ------------------------------------------------------------------
    // State machine, pool registers and the output register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            kcount_reg  <= '0;
            ucount_reg  <= '0;
            kbase_reg   <= '0;
            split_reg   <= '0;
            end_reg     <= '0;
            sweep_reg   <= '0;
        end else begin
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (rd_en) begin
                        mode_reg  <= mode_t'(s_tuser[1:0]);
                        pool_reg  <= s_tuser[2];
                        addr_reg  <= s_tdata;
                        bp_reg    <= bp_calc;
                        ep_reg    <= ep_calc;
                        state_reg <= (mode_t'(s_tuser[1:0]) == MODE_INIT) ? ST_INIT_SIZE
                                                                          : ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        if (pool_reg) begin
                            kcount_reg <= exec_count;
                        end else begin
                            ucount_reg <= exec_count;
                        end
                        m_valid_reg  <= 1'b1;
                        m_page_reg   <= exec_page;
                        m_status_reg <= exec_status;
                        m_kern_reg   <= exec_kern;
                        m_free_reg   <= FREE_W'(exec_count);
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_INIT_SIZE: begin
                    pages_reg <= area_pages;
                    if (area_empty) begin
                        // Fewer than two pages: both pools become empty.
                        kcount_reg     <= '0;
                        ucount_reg     <= '0;
                        kbase_reg      <= '0;
                        split_reg      <= '0;
                        end_reg        <= '0;
                        fin_status_reg <= STAT_EMPTY_AREA;
                        state_reg      <= ST_FIN;
                    end else begin
                        kbase_reg <= bp_reg[PG_W-1:0];
                        state_reg <= ST_INIT_SPLIT;
                    end
                end
                ST_INIT_SPLIT: begin
                    kcount_reg     <= kp_calc;
                    ucount_reg     <= up_wide[CNT_W-1:0];
                    split_reg      <= kbase_reg + PG_W'(kp_calc);
                    end_reg        <= kbase_reg + PG_W'(pages_reg);
                    sweep_reg      <= '0;
                    fin_status_reg <= STAT_OK;
                    state_reg      <= ST_SWEEP;
                end
                ST_SWEEP: begin
                    // Each pool stack gets offsets in ascending order.
                    sweep_reg <= sweep_reg + CNT_W'(1);
                    if (sweep_reg == SWEEP_END) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_page_reg   <= '0;
                        m_status_reg <= fin_status_reg;
                        m_kern_reg   <= 1'b0;
                        m_free_reg   <= FREE_W'(pool_reg ? kcount_reg : ucount_reg);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `TPA_ASSERT(a_accept_starts_work, aclk, aresetn, (s_tvalid && s_tready) |=> (state_reg != ST_IDLE), "accepted word did not start work")
    `TPA_ASSERT(a_counts_in_capacity, aclk, aresetn, (kcount_reg <= CNT_MAX) && (ucount_reg <= CNT_MAX), "pool count exceeds capacity")
    `TPA_ASSERT(a_result_from_step, aclk, aresetn, $rose(m_valid_reg) |-> ($past(state_reg) == ST_EXEC || $past(state_reg) == ST_FIN), "result appeared outside a finishing step")

endmodule

`default_nettype wire

/* sim/two_pool_page_allocator_unit_tb.sv */
// Self-checking stream and APB testbench for the two-pool page allocator.
`timescale 1ns / 1ps

// The bench drives request words into the allocator's input stream and checks every result
// word against its own model of both pools. The model tracks the page stacks, the free
// bitmaps, the pool ranges and the programmed area registers. The area registers are
// reprogrammed only while the block is idle. A short directed part comes first: empty pools
// after reset, an empty area, begin past end, a two-page area with an unaligned begin, the
// clamped full-size area and an area at the top of the address space. Random sessions
// follow, each with a fresh area and mostly well-formed alloc/free traffic that recycles
// handed-out pages. Three pacing phases vary how often the sender and the receiver stall.
module two_pool_page_allocator_unit_tb;
    import tpa_pkg::*;

    localparam int PAGE_BITS   = 12;
    localparam int POOL_PAGES  = 4096;
    localparam int OFFS_W      = 12;
    localparam int MAX_CYCLES  = 1_000_000;
    localparam int PHASE_WORDS = 233;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        mode_t             mode;
        logic              kern;
        logic [ADDR_W-1:0] addr;
    } page_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] page_addr;
        status_t           status;
        logic              is_kernel;
        logic [FREE_W-1:0] free_pages;
    } page_resp_t;

    typedef struct packed {
        logic              kern;
        logic [ADDR_W-1:0] addr;
    } page_ref_t;

    // Clock, reset and every block input start from known values.
    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [ADDR_W-1:0] s_tdata  = '0;
    logic [IN_UW-1:0]  s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Request words waiting for the driver, and predicted result words waiting for the DUT.
    page_req_t  req_q[$];
    page_resp_t resp_q[$];
    page_req_t  cur_req;
    // Pages handed out by the model; the stimulus frees them back to keep pools cycling.
    page_ref_t  granted_pages[$];

    // Model of the allocator: area registers, pool ranges, stacks, bitmaps and counts.
    // Index 1 of the per-pool arrays is the kernel pool, index 0 the user pool.
    logic [ADDR_W-1:0] area_lo = '0;
    logic [ADDR_W-1:0] area_hi = '0;
    logic [63:0]       base_page  = '0;
    logic [63:0]       split_page = '0;
    logic [63:0]       end_page   = '0;
    logic [OFFS_W-1:0] page_stack [2][POOL_PAGES];
    bit                free_map   [2][POOL_PAGES];
    int unsigned       free_cnt   [2] = '{0, 0};

    int words_issued   = 0;
    int words_accepted = 0;
    int mismatches     = 0;
    int area_settings  = 0;
    int outcome_cnt [5] = '{0, 0, 0, 0, 0};
    int snd_idle_pct   = 17;
    int rcv_idle_pct   = 62;
    int cycle_count;

    two_pool_page_allocator_unit #(
        .PAGE_BITS (PAGE_BITS),
        .POOL_PAGES(POOL_PAGES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [55:0] address
        .s_tuser (s_tuser),   // [1:0] mode, [2] pool
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // [55:0] page_address, [58:56] status, [59] is_kernel,
                              // [72:60] free_pages, [79:73] zero
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Work out the result of one accepted request word and advance the pool model.
    function automatic page_resp_t predict_step(page_req_t req);
        page_resp_t  r;
        logic [63:0] bp, ep, pages, kp, lo, hi, pg, pa;
        int unsigned off;
        int          p;
        int          i;
        r  = '0;
        p  = req.kern ? 1 : 0;
        lo = req.kern ? base_page : split_page;
        hi = req.kern ? split_page : end_page;
        pg = {8'h00, req.addr} >> PAGE_BITS;
        case (req.mode)
            MODE_INIT: begin
                bp = ({8'h00, area_lo} >> PAGE_BITS) + (area_lo[PAGE_BITS-1:0] != '0);
                ep = {8'h00, area_hi} >> PAGE_BITS;
                pages = 0;
                // Fewer than two pages, or begin past end, leaves both pools empty.
                if (bp < ep && ep - bp >= 2) begin
                    pages = ep - bp;
                    if (pages > 2 * POOL_PAGES) pages = 2 * POOL_PAGES;
                end else begin
                    r.status = STAT_EMPTY_AREA;
                end
                // The kernel pool takes the lower half; the user pool gets the odd page.
                kp         = pages / 2;
                base_page  = (pages != 0) ? bp : '0;
                split_page = base_page + kp;
                end_page   = base_page + pages;
                for (i = 0; i < POOL_PAGES; i++) begin
                    page_stack[1][i] = OFFS_W'(i);
                    page_stack[0][i] = OFFS_W'(i);
                    free_map[1][i]   = (i < kp);
                    free_map[0][i]   = (i < pages - kp);
                end
                free_cnt[1] = kp;
                free_cnt[0] = pages - kp;
                granted_pages.delete();
            end
            MODE_ALLOC: begin
                if (free_cnt[p] == 0 || free_cnt[p] > POOL_PAGES) begin
                    r.status = STAT_EXHAUSTED;
                end else begin
                    // Last pushed page goes out first.
                    free_cnt[p]--;
                    off = page_stack[p][free_cnt[p]] % POOL_PAGES;
                    free_map[p][off] = 1'b0;
                    pa = (lo + off) << PAGE_BITS;
                    r.page_addr = pa[ADDR_W-1:0];
                    granted_pages.push_back('{req.kern, r.page_addr});
                end
            end
            MODE_FREE: begin
                if (req.addr[PAGE_BITS-1:0] != '0 || pg < lo || pg >= hi
                        || pg - lo >= POOL_PAGES) begin
                    r.status = STAT_BAD_FREE;
                end else begin
                    off = pg - lo;
                    if (free_map[p][off] || free_cnt[p] >= POOL_PAGES) begin
                        r.status = STAT_DOUBLE_FREE;
                    end else begin
                        free_map[p][off] = 1'b1;
                        page_stack[p][free_cnt[p]] = OFFS_W'(off);
                        free_cnt[p]++;
                    end
                end
            end
            default: begin
                r.is_kernel = (pg >= base_page && pg < split_page);
            end
        endcase
        r.free_pages = FREE_W'(free_cnt[p]);
        outcome_cnt[r.status]++;
        return r;
    endfunction

    // Driver: on each accepted word the model predicts its result; then the next pending
    // word is presented unless the sender idles this cycle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                resp_q.push_back(predict_step(cur_req));
                words_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (req_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                    cur_req = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_req.addr;
                    s_tuser  <= {cur_req.kern, cur_req.mode};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Compare one result word, field by field, with the oldest prediction.
    task automatic check_word(input logic [OUT_DW-1:0] word);
        page_resp_t want;
        if (resp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] result word %h arrived with nothing outstanding", $time, word);
        end else begin
            want = resp_q.pop_front();
            if (word[ADDR_W-1:0] !== want.page_addr
                    || word[ADDR_W+2:ADDR_W] !== want.status
                    || word[ADDR_W+3] !== want.is_kernel
                    || word[ADDR_W+16:ADDR_W+4] !== want.free_pages
                    || word[OUT_DW-1:ADDR_W+17] !== '0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] expected addr %h status %0d kernel %b free %0d, got addr %h status %0d kernel %b free %0d pad %h",
                             $time, want.page_addr, want.status, want.is_kernel,
                             want.free_pages, word[ADDR_W-1:0], word[ADDR_W+2:ADDR_W],
                             word[ADDR_W+3], word[ADDR_W+16:ADDR_W+4],
                             word[OUT_DW-1:ADDR_W+17]);
            end
        end
    endtask

    // Monitor: checks accepted result words and stalls the output at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_word(m_tdata);
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] page_to_addr(input logic [63:0] pg);
        logic [63:0] a;
        a = pg << PAGE_BITS;
        return a[ADDR_W-1:0];
    endfunction

    function automatic void queue_req(input mode_t mode, input logic kern,
                                      input logic [ADDR_W-1:0] addr);
        req_q.push_back('{mode, kern, addr});
        words_issued++;
    endfunction

    task automatic wait_accepted();
        while (words_accepted != words_issued) @(posedge aclk);
    endtask

    // The block is idle once every issued word has been accepted and answered.
    task automatic wait_idle();
        while (words_accepted != words_issued || resp_q.size() != 0) @(posedge aclk);
    endtask

    // One APB write: setup cycle, then access cycle until pready.
    task automatic program_reg(input logic idx, input logic [APB_DW-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Bits above the 56-bit address are dropped by the register.
        if (idx == REG_AREA_BEGIN) area_lo = value[ADDR_W-1:0];
        else area_hi = value[ADDR_W-1:0];
    endtask

    task automatic program_area(input logic [APB_DW-1:0] lo_v, input logic [APB_DW-1:0] hi_v);
        wait_idle();
        program_reg(REG_AREA_BEGIN, lo_v);
        program_reg(REG_AREA_END, hi_v);
        area_settings++;
    endtask

    // Random traffic against the current area, issued in small batches so that frees can
    // pick pages the model has already handed out.
    task automatic run_ops(input int n_words);
        int          k, sel, idx;
        logic        kern;
        logic [63:0] lo, hi, pg;
        page_ref_t   pr;
        for (k = 0; k < n_words; k++) begin
            if (k % 8 == 0) wait_accepted();
            kern = $urandom_range(1);
            lo   = kern ? base_page : split_page;
            hi   = kern ? split_page : end_page;
            sel  = $urandom_range(99);
            if (sel < 38 || (sel < 68 && granted_pages.size() == 0)) begin
                // The address of an allocate is ignored, so it carries random bits.
                queue_req(MODE_ALLOC, kern, rand_addr());
            end else if (sel < 68) begin
                idx = $urandom_range(granted_pages.size() - 1);
                pr  = granted_pages[idx];
                granted_pages.delete(idx);
                queue_req(MODE_FREE, pr.kern, pr.addr);
            end else if (sel < 76) begin
                // Aligned page inside the pool; a double free unless it is handed out.
                pg = (hi > lo) ? lo + $urandom_range(32'(hi - lo - 1)) : lo;
                queue_req(MODE_FREE, kern, page_to_addr(pg));
            end else if (sel < 82) begin
                case ($urandom_range(3))
                    0: queue_req(MODE_FREE, kern,
                                 page_to_addr(lo) | ADDR_W'($urandom_range(4095, 1)));
                    1: queue_req(MODE_FREE, kern, page_to_addr(lo - 1));
                    2: queue_req(MODE_FREE, kern, page_to_addr(hi));
                    default: queue_req(MODE_FREE, kern,
                                       page_to_addr(kern ? split_page : base_page));
                endcase
            end else if (sel < 92) begin
                // Membership checks around the kernel range edges, or at a random page above the pool base.
                case ($urandom_range(4))
                    0: pg = base_page - 1;
                    1: pg = base_page;
                    2: pg = split_page - 1;
                    3: pg = split_page;
                    default: pg = lo + $urandom_range(8191);
                endcase
                queue_req(MODE_CHECK, kern,
                          page_to_addr(pg) | ADDR_W'($urandom_range(4095)));
            end else if (sel < 98) begin
                queue_req(mode_t'($urandom_range(3, 1)), kern, rand_addr());
            end else begin
                queue_req(MODE_INIT, kern, rand_addr());
            end
        end
    endtask

    // One session: a fresh area, an initialize, then random traffic.
    task automatic random_area_session();
        logic [63:0] lo_v, hi_v, tmp, span;
        int          sel;
        sel  = $urandom_range(99);
        lo_v = {$urandom, $urandom} & 64'h007F_FFFF_FFFF_FFFF;
        if (sel < 58) span = $urandom_range(40, 2);
        else if (sel < 70) span = $urandom_range(1);
        else if (sel < 82) span = $urandom_range(300, 41);
        else span = $urandom_range(9000, 7900);
        hi_v = lo_v + (span << PAGE_BITS) + $urandom_range(4095);
        if (sel % 17 == 0) begin
            tmp  = lo_v;
            lo_v = hi_v;
            hi_v = tmp;
        end
        lo_v[63:56] = $urandom_range(255);
        hi_v[63:56] = $urandom_range(255);
        program_area(lo_v, hi_v);
        queue_req(MODE_INIT, $urandom_range(1), rand_addr());
        run_ops($urandom_range(50, 20));
    endtask

    initial begin
        int phase, start;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Nothing initialized yet: both pools are empty ranges.
        queue_req(MODE_ALLOC, 1'b1, '0);
        queue_req(MODE_FREE, 1'b0, '0);
        queue_req(MODE_CHECK, 1'b1, '0);
        // Empty area, then begin past end once both are rounded.
        program_area('0, '0);
        queue_req(MODE_INIT, 1'b1, '0);
        program_area('1, '1);
        queue_req(MODE_INIT, 1'b0, '1);
        // Unaligned begin leaves two pages: kernel page 2, user page 3.
        program_area(64'h1001, 64'h4000);
        queue_req(MODE_INIT, 1'b1, '0);
        queue_req(MODE_ALLOC, 1'b1, '0);
        queue_req(MODE_ALLOC, 1'b1, '0);
        queue_req(MODE_ALLOC, 1'b0, '0);
        queue_req(MODE_FREE, 1'b0, 56'h3000);
        queue_req(MODE_FREE, 1'b0, 56'h3000);
        queue_req(MODE_FREE, 1'b1, 56'h2001);
        queue_req(MODE_FREE, 1'b1, 56'h3000);
        queue_req(MODE_CHECK, 1'b0, 56'h2fff);
        queue_req(MODE_CHECK, 1'b1, 56'h3000);
        // Whole address space: clamped to two full pools.
        program_area('0, '1);
        queue_req(MODE_INIT, 1'b0, '0);
        queue_req(MODE_ALLOC, 1'b1, '1);
        queue_req(MODE_FREE, 1'b1, 56'h0_0fff_000);
        queue_req(MODE_CHECK, 1'b1, '1);
        queue_req(MODE_CHECK, 1'b0, '0);
        // Two pages at the very top of the address space.
        program_area(64'h00FF_FFFF_FFFF_D000, 64'h00FF_FFFF_FFFF_FFFF);
        queue_req(MODE_INIT, 1'b1, '0);
        queue_req(MODE_ALLOC, 1'b0, '0);
        queue_req(MODE_FREE, 1'b0, '1);

        // Pacing phases: sender idles less than receiver, then the reverse, then no idling.
        for (phase = 0; phase < 3; phase++) begin
            snd_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 62 : 0;
            rcv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 17 : 0;
            start = words_issued;
            while (words_issued - start < PHASE_WORDS) random_area_session();
        end

        wait_idle();
        repeat (16) @(posedge aclk);
        $display("Ran %0d request words over %0d area settings in three pacing phases.",
                 words_accepted, area_settings);
        $display("Outcomes: %0d ok, %0d exhausted, %0d invalid free, %0d double free, %0d empty area; %0d mismatches.",
                 outcome_cnt[STAT_OK], outcome_cnt[STAT_EXHAUSTED],
                 outcome_cnt[STAT_BAD_FREE], outcome_cnt[STAT_DOUBLE_FREE],
                 outcome_cnt[STAT_EMPTY_AREA], mismatches);
        if (mismatches == 0) begin
            $display("PASS two_pool_page_allocator_unit");
        end else begin
            $display("FAIL two_pool_page_allocator_unit");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        for (cycle_count = 0; cycle_count < MAX_CYCLES; cycle_count++) @(posedge aclk);
        $display("FAIL two_pool_page_allocator_unit");
        $finish;
    end

endmodule
